[hw/rtl/plbq_pkg.sv]
// ----------------------------------------------------------------------------
// Price level book package
// Shared constants, the sequencer state type and the find-first function
// used by the price level book.
// ----------------------------------------------------------------------------
package plbq_pkg;

    localparam int unsigned LEVELS_DEF     = 4096;
    localparam int unsigned PRICE_STEP_DEF = 1;

    localparam int unsigned PRICE_W    = 32;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BIT_W      = 5;
    localparam int unsigned SLOT_PAD_W = 20;

    localparam logic SIDE_BID   = 1'b0;
    localparam logic SIDE_ASK   = 1'b1;
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_L0_RD,
        S_L0_WR,
        S_L1_WR,
        S_L2_WR,
        S_Q_TOP,
        S_Q_L2,
        S_Q_L1,
        S_Q_L0,
        S_Q_DATA,
        S_DONE
    } state_t;

    // Returns the position of the highest or the lowest set bit of a word.
    function automatic logic [BIT_W-1:0] find_bit(input logic [WORD_W-1:0] word,
                                                   input logic highest);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (highest)
            begin
                if (word[i])
                begin
                    pos = BIT_W'(i);
                end
            end
            else
            begin
                if (word[WORD_W-1-i])
                begin
                    pos = BIT_W'(WORD_W-1-i);
                end
            end
        end
        return pos;
    endfunction

endpackage

[hw/rtl/price_level_book_best_quote_top.sv]
// ----------------------------------------------------------------------------
// Price level book with best quote
// Writes at most one bid or ask level per command and reports the best bid
// and the best ask after every command.
// ----------------------------------------------------------------------------
// Each command writes at most one price level and returns one result, shown
// for one cycle with done high; the result cannot be stalled. A command runs
// through the slot division (a reciprocal multiplication, skipped when
// PRICE_STEP is 1), a read-modify-write of three levels of the occupancy bitmap
// and two walks down that bitmap through a shared find-first unit, each step
// waiting on a single-port memory read. A rejected write skips the division
// and the bitmap write, and the walk of an empty side is cut short. busy stays
// high while done is shown; the next command is taken only from idle. After
// reset the bitmap is cleared while busy is high; cfg_we is taken at any time.
module price_level_book_best_quote_top #(
    parameter int unsigned LEVELS     = plbq_pkg::LEVELS_DEF,
    parameter int unsigned PRICE_STEP = plbq_pkg::PRICE_STEP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] size,
    output logic        done,
    output logic        accepted,
    output logic        bid_valid,
    output logic [31:0] best_bid_price,
    output logic [31:0] best_bid_size,
    output logic        ask_valid,
    output logic [31:0] best_ask_price,
    output logic [31:0] best_ask_size
);

    localparam int unsigned WORD_W   = plbq_pkg::WORD_W;
    localparam int unsigned BIT_W    = plbq_pkg::BIT_W;
    localparam int unsigned PAD_W    = plbq_pkg::SLOT_PAD_W;
    localparam int unsigned DATA_W   = plbq_pkg::PRICE_W + plbq_pkg::SIZE_W;
    localparam int unsigned SLOT_W   = $clog2(LEVELS);
    localparam int unsigned STEP_W   = 1;
    localparam int unsigned L0_DEPTH = (LEVELS + WORD_W - 1) / WORD_W;
    localparam int unsigned L1_DEPTH = (L0_DEPTH + WORD_W - 1) / WORD_W;
    localparam int unsigned L2_DEPTH = (L1_DEPTH + WORD_W - 1) / WORD_W;
    localparam int unsigned DATA_AW  = $clog2(2 * LEVELS);
    localparam int unsigned L0_AW    = $clog2(2 * L0_DEPTH);
    localparam int unsigned L1_AW    = $clog2(2 * L1_DEPTH);
    localparam int unsigned L2_AW    = $clog2(2 * L2_DEPTH);
    localparam logic [63:0] SPAN     = 64'(LEVELS) * 64'(PRICE_STEP);

    // Division by the price step as a multiply-high by its reciprocal
    // followed by a fix-up add and shift, exact for every 32-bit dividend.
    localparam int unsigned DIV_L    = $clog2(PRICE_STEP);
    localparam int unsigned DIV_SH1  = (DIV_L > 0) ? 1 : 0;
    localparam int unsigned DIV_SH2  = (DIV_L > 0) ? DIV_L - 1 : 0;
    localparam logic [63:0] RECIP_W  =
        ((((64'd1 << DIV_L) - 64'(PRICE_STEP)) << 32) / 64'(PRICE_STEP)) + 64'd1;
    localparam logic [31:0] RECIP_M  = RECIP_W[31:0];

    plbq_pkg::state_t state_reg, state_next;

    logic [L0_AW-1:0]  clr_reg, clr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [31:0]       min_price_reg, min_price_next;
    logic [WORD_W-1:0] top_bid_reg, top_bid_next;
    logic [WORD_W-1:0] top_ask_reg, top_ask_next;

    logic              action_reg, action_next;
    logic              side_reg, side_next;
    logic [31:0]       price_reg, price_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       mhi_reg, mhi_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              nz_reg, nz_next;
    logic              qside_reg, qside_next;
    logic [PAD_W-1:0]  path_reg, path_next;
    logic              acc_reg, acc_next;
    logic              bid_v_reg, bid_v_next;
    logic [31:0]       bid_p_reg, bid_p_next;
    logic [31:0]       bid_s_reg, bid_s_next;
    logic              ask_v_reg, ask_v_next;
    logic [31:0]       ask_p_reg, ask_p_next;
    logic [31:0]       ask_s_reg, ask_s_next;

    logic              data_we;
    logic [DATA_AW-1:0] data_addr;
    logic [DATA_W-1:0] data_rdata;
    logic              l0_we, l1_we, l2_we;
    logic [L0_AW-1:0]  l0_addr;
    logic [L1_AW-1:0]  l1_addr;
    logic [L2_AW-1:0]  l2_addr;
    logic [WORD_W-1:0] l0_rdata, l1_rdata, l2_rdata;
    logic [WORD_W-1:0] word_wdata;

    logic [PAD_W-1:0]  slot_pad;
    logic [PAD_W-1:0]  found_slot;
    logic [31:0]       diff;
    logic              in_range;
    logic [63:0]       prod;
    logic [31:0]       quot;
    logic              mark;
    logic              clr_end;
    logic [WORD_W-1:0] q_top_word;
    logic [WORD_W-1:0] ff_word;
    logic [BIT_W-1:0]  ff_pos;
    logic [WORD_W-1:0] mod_in, mod_out;
    logic [BIT_W-1:0]  mod_pos;
    logic              mod_bit;
    logic              mod_nz;

    plbq_ram #(.WIDTH(DATA_W), .DEPTH(2 * LEVELS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .addr  (data_addr),
        .wdata ({price_reg, size_reg}),
        .rdata (data_rdata)
    );

    plbq_ram #(.WIDTH(WORD_W), .DEPTH(2 * L0_DEPTH)) u_l0_ram (
        .clk   (clk),
        .we    (l0_we),
        .addr  (l0_addr),
        .wdata (word_wdata),
        .rdata (l0_rdata)
    );

    plbq_ram #(.WIDTH(WORD_W), .DEPTH(2 * L1_DEPTH)) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .addr  (l1_addr),
        .wdata (word_wdata),
        .rdata (l1_rdata)
    );

    plbq_ram #(.WIDTH(WORD_W), .DEPTH(2 * L2_DEPTH)) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .addr  (l2_addr),
        .wdata (word_wdata),
        .rdata (l2_rdata)
    );

    assign slot_pad   = PAD_W'(slot_reg);
    assign diff       = price_reg - min_price_reg;
    assign in_range   = (price_reg >= min_price_reg) && ({32'b0, diff} < SPAN);
    assign prod       = 64'(rem_reg) * 64'(RECIP_M);
    assign quot       = (mhi_reg + ((rem_reg - mhi_reg) >> DIV_SH1)) >> DIV_SH2;
    assign mark       = (action_reg == plbq_pkg::ACT_INSERT) || (size_reg != '0);
    assign clr_end    = clr_reg == L0_AW'(2 * L0_DEPTH - 1);
    assign q_top_word = (qside_reg == plbq_pkg::SIDE_BID) ? top_bid_reg : top_ask_reg;

    // The bid walk follows the highest set bit, the ask walk the lowest.
    always_comb
    begin
        unique case (state_reg)
            plbq_pkg::S_Q_L2: ff_word = l2_rdata;
            plbq_pkg::S_Q_L1: ff_word = l1_rdata;
            plbq_pkg::S_Q_L0: ff_word = l0_rdata;
            default:          ff_word = q_top_word;
        endcase
        ff_pos     = plbq_pkg::find_bit(ff_word, qside_reg == plbq_pkg::SIDE_BID);
        found_slot = {path_reg[PAD_W-1:BIT_W], ff_pos};
    end

    always_comb
    begin
        unique case (state_reg)
            plbq_pkg::S_L1_WR:
            begin
                mod_in  = l1_rdata;
                mod_pos = slot_pad[2*BIT_W-1:BIT_W];
                mod_bit = nz_reg;
            end
            plbq_pkg::S_L2_WR:
            begin
                mod_in  = l2_rdata;
                mod_pos = slot_pad[3*BIT_W-1:2*BIT_W];
                mod_bit = nz_reg;
            end
            default:
            begin
                mod_in  = l0_rdata;
                mod_pos = slot_pad[BIT_W-1:0];
                mod_bit = mark;
            end
        endcase
        mod_out          = mod_in;
        mod_out[mod_pos] = mod_bit;
        mod_nz           = |mod_out;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plbq_pkg::S_CLEAR:
            begin
                if (clr_end)
                begin
                    state_next = plbq_pkg::S_IDLE;
                end
            end
            plbq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = plbq_pkg::S_CHECK;
                end
            end
            plbq_pkg::S_CHECK:
            begin
                priority if (!in_range)
                begin
                    state_next = plbq_pkg::S_Q_TOP;
                end
                else if (PRICE_STEP == 1)
                begin
                    state_next = plbq_pkg::S_L0_RD;
                end
                else
                begin
                    state_next = plbq_pkg::S_DIV;
                end
            end
            plbq_pkg::S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = plbq_pkg::S_L0_RD;
                end
            end
            plbq_pkg::S_L0_RD:  state_next = plbq_pkg::S_L0_WR;
            plbq_pkg::S_L0_WR:  state_next = plbq_pkg::S_L1_WR;
            plbq_pkg::S_L1_WR:  state_next = plbq_pkg::S_L2_WR;
            plbq_pkg::S_L2_WR:  state_next = plbq_pkg::S_Q_TOP;
            plbq_pkg::S_Q_TOP:
            begin
                priority if (q_top_word != '0)
                begin
                    state_next = plbq_pkg::S_Q_L2;
                end
                else if (qside_reg == plbq_pkg::SIDE_ASK)
                begin
                    state_next = plbq_pkg::S_DONE;
                end
                else
                begin
                    state_next = plbq_pkg::S_Q_TOP;
                end
            end
            plbq_pkg::S_Q_L2:   state_next = plbq_pkg::S_Q_L1;
            plbq_pkg::S_Q_L1:   state_next = plbq_pkg::S_Q_L0;
            plbq_pkg::S_Q_L0:   state_next = plbq_pkg::S_Q_DATA;
            plbq_pkg::S_Q_DATA:
            begin
                if (qside_reg == plbq_pkg::SIDE_ASK)
                begin
                    state_next = plbq_pkg::S_DONE;
                end
                else
                begin
                    state_next = plbq_pkg::S_Q_TOP;
                end
            end
            plbq_pkg::S_DONE:   state_next = plbq_pkg::S_IDLE;
            default:            state_next = plbq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = state_reg != plbq_pkg::S_IDLE;
        done       = state_reg == plbq_pkg::S_DONE;
        data_we    = 1'b0;
        l0_we      = 1'b0;
        l1_we      = 1'b0;
        l2_we      = 1'b0;
        word_wdata = mod_out;
        data_addr  = DATA_AW'(slot_reg)
                   + ((side_reg == plbq_pkg::SIDE_ASK) ? DATA_AW'(LEVELS) : '0);
        l0_addr    = L0_AW'(slot_pad[PAD_W-1:BIT_W])
                   + ((side_reg == plbq_pkg::SIDE_ASK) ? L0_AW'(L0_DEPTH) : '0);
        l1_addr    = L1_AW'(slot_pad[PAD_W-1:2*BIT_W])
                   + ((side_reg == plbq_pkg::SIDE_ASK) ? L1_AW'(L1_DEPTH) : '0);
        l2_addr    = L2_AW'(slot_pad[PAD_W-1:3*BIT_W])
                   + ((side_reg == plbq_pkg::SIDE_ASK) ? L2_AW'(L2_DEPTH) : '0);
        unique case (state_reg)
            plbq_pkg::S_CLEAR:
            begin
                word_wdata = '0;
                l0_we      = 1'b1;
                l1_we      = 32'(clr_reg) < 32'(2 * L1_DEPTH);
                l2_we      = 32'(clr_reg) < 32'(2 * L2_DEPTH);
                l0_addr    = clr_reg;
                l1_addr    = L1_AW'(clr_reg);
                l2_addr    = L2_AW'(clr_reg);
            end
            plbq_pkg::S_L0_RD:  data_we = 1'b1;
            plbq_pkg::S_L0_WR:  l0_we   = 1'b1;
            plbq_pkg::S_L1_WR:  l1_we   = 1'b1;
            plbq_pkg::S_L2_WR:  l2_we   = 1'b1;
            plbq_pkg::S_Q_TOP:
            begin
                l2_addr = L2_AW'(ff_pos)
                        + ((qside_reg == plbq_pkg::SIDE_ASK) ? L2_AW'(L2_DEPTH) : '0);
            end
            plbq_pkg::S_Q_L2:
            begin
                l1_addr = L1_AW'({path_reg[PAD_W-1:3*BIT_W], ff_pos})
                        + ((qside_reg == plbq_pkg::SIDE_ASK) ? L1_AW'(L1_DEPTH) : '0);
            end
            plbq_pkg::S_Q_L1:
            begin
                l0_addr = L0_AW'({path_reg[PAD_W-1:2*BIT_W], ff_pos})
                        + ((qside_reg == plbq_pkg::SIDE_ASK) ? L0_AW'(L0_DEPTH) : '0);
            end
            plbq_pkg::S_Q_L0:
            begin
                data_addr = DATA_AW'(found_slot)
                          + ((qside_reg == plbq_pkg::SIDE_ASK) ? DATA_AW'(LEVELS) : '0);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        min_price_next = cfg_we ? cfg_wdata : min_price_reg;
        top_bid_next   = top_bid_reg;
        top_ask_next   = top_ask_reg;
        action_next    = action_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        size_next      = size_reg;
        rem_next       = rem_reg;
        mhi_next       = mhi_reg;
        slot_next      = slot_reg;
        nz_next        = nz_reg;
        qside_next     = qside_reg;
        path_next      = path_reg;
        acc_next       = acc_reg;
        bid_v_next     = bid_v_reg;
        bid_p_next     = bid_p_reg;
        bid_s_next     = bid_s_reg;
        ask_v_next     = ask_v_reg;
        ask_p_next     = ask_p_reg;
        ask_s_next     = ask_s_reg;
        unique case (state_reg)
            plbq_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            plbq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    side_next   = side;
                    price_next  = price;
                    size_next   = size;
                    qside_next  = plbq_pkg::SIDE_BID;
                end
            end
            plbq_pkg::S_CHECK:
            begin
                acc_next  = in_range;
                rem_next  = diff;
                cnt_next  = STEP_W'(1);
                slot_next = (PRICE_STEP == 1) ? SLOT_W'(diff) : '0;
            end
            plbq_pkg::S_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    mhi_next = prod[63:32];
                end
                else
                begin
                    slot_next = SLOT_W'(quot);
                end
                cnt_next = cnt_reg - 1'b1;
            end
            plbq_pkg::S_L0_WR,
            plbq_pkg::S_L1_WR:
            begin
                nz_next = mod_nz;
            end
            plbq_pkg::S_L2_WR:
            begin
                if (side_reg == plbq_pkg::SIDE_BID)
                begin
                    top_bid_next[slot_pad[PAD_W-1:3*BIT_W]] = mod_nz;
                end
                else
                begin
                    top_ask_next[slot_pad[PAD_W-1:3*BIT_W]] = mod_nz;
                end
            end
            plbq_pkg::S_Q_TOP:
            begin
                path_next[PAD_W-1:3*BIT_W] = ff_pos;
                if (q_top_word == '0)
                begin
                    qside_next = plbq_pkg::SIDE_ASK;
                    if (qside_reg == plbq_pkg::SIDE_BID)
                    begin
                        bid_v_next = 1'b0;
                        bid_p_next = '0;
                        bid_s_next = '0;
                    end
                    else
                    begin
                        ask_v_next = 1'b0;
                        ask_p_next = '0;
                        ask_s_next = '0;
                    end
                end
            end
            plbq_pkg::S_Q_L2:
            begin
                path_next[3*BIT_W-1:2*BIT_W] = ff_pos;
            end
            plbq_pkg::S_Q_L1:
            begin
                path_next[2*BIT_W-1:BIT_W] = ff_pos;
            end
            plbq_pkg::S_Q_L0:
            begin
                path_next[BIT_W-1:0] = ff_pos;
            end
            plbq_pkg::S_Q_DATA:
            begin
                qside_next = plbq_pkg::SIDE_ASK;
                if (qside_reg == plbq_pkg::SIDE_BID)
                begin
                    bid_v_next = 1'b1;
                    bid_p_next = data_rdata[DATA_W-1:32];
                    bid_s_next = data_rdata[31:0];
                end
                else
                begin
                    ask_v_next = 1'b1;
                    ask_p_next = data_rdata[DATA_W-1:32];
                    ask_s_next = data_rdata[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plbq_pkg::S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            min_price_reg <= '0;
            top_bid_reg   <= '0;
            top_ask_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            min_price_reg <= min_price_next;
            top_bid_reg   <= top_bid_next;
            top_ask_reg   <= top_ask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        side_reg   <= side_next;
        price_reg  <= price_next;
        size_reg   <= size_next;
        rem_reg    <= rem_next;
        mhi_reg    <= mhi_next;
        slot_reg   <= slot_next;
        nz_reg     <= nz_next;
        qside_reg  <= qside_next;
        path_reg   <= path_next;
        acc_reg    <= acc_next;
        bid_v_reg  <= bid_v_next;
        bid_p_reg  <= bid_p_next;
        bid_s_reg  <= bid_s_next;
        ask_v_reg  <= ask_v_next;
        ask_p_reg  <= ask_p_next;
        ask_s_reg  <= ask_s_next;
    end

    assign accepted       = acc_reg;
    assign bid_valid      = bid_v_reg;
    assign best_bid_price = bid_p_reg;
    assign best_bid_size  = bid_s_reg;
    assign ask_valid      = ask_v_reg;
    assign best_ask_price = ask_p_reg;
    assign best_ask_size  = ask_s_reg;

`ifndef SYNTH
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_start_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_empty_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !bid_valid) |-> (best_bid_price == '0 && best_bid_size == '0))
        else $error("empty bid side reported nonzero quote");

    a_empty_ask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ask_valid) |-> (best_ask_price == '0 && best_ask_size == '0))
        else $error("empty ask side reported nonzero quote");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plbq_pkg::S_L0_RD) |-> (32'(slot_reg) < LEVELS))
        else $error("slot beyond the book written");
`endif

endmodule

[hw/rtl/plbq_ram.sv]
// ----------------------------------------------------------------------------
// Price level book RAM
// Generic single-port memory with one write or read address per cycle and
// registered read data.
// ----------------------------------------------------------------------------
module plbq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[bench/price_level_book_best_quote_checker.sv]
// ----------------------------------------------------------------------------
// Price level book checker
// Watches the configuration port, the command port and the result strobe of
// the price level book. For every command transfer it updates its own copy
// of the book and predicts the accept flag and the best bid and best ask;
// each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module price_level_book_best_quote_checker #(
    parameter int unsigned LEVELS     = plbq_pkg::LEVELS_DEF,
    parameter int unsigned PRICE_STEP = plbq_pkg::PRICE_STEP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] size,
    input  logic        done,
    input  logic        accepted,
    input  logic        bid_valid,
    input  logic [31:0] best_bid_price,
    input  logic [31:0] best_bid_size,
    input  logic        ask_valid,
    input  logic [31:0] best_ask_price,
    input  logic [31:0] best_ask_size,
    output int          errors,
    output int          pending,
    output int          results,
    output int          applied
);

    typedef struct packed {
        logic        accepted;
        logic        bid_valid;
        logic [31:0] bid_price;
        logic [31:0] bid_size;
        logic        ask_valid;
        logic [31:0] ask_price;
        logic [31:0] ask_size;
    } quote_t;

    bit [31:0] base_price;
    bit [31:0] bid_price_tab [LEVELS];
    bit [31:0] bid_size_tab  [LEVELS];
    bit [31:0] ask_price_tab [LEVELS];
    bit [31:0] ask_size_tab  [LEVELS];
    bit        bid_marks     [LEVELS];
    bit        ask_marks     [LEVELS];

    quote_t quote_q[$];
    int     mismatches;
    int     quotes_seen;
    int     writes_applied;

    function automatic quote_t write_level(input logic act, input logic sd,
                                           input logic [31:0] px,
                                           input logic [31:0] qty);
        quote_t      q;
        logic [31:0] slot;
        logic        mark;
        q = '0;
        if (px >= base_price)
        begin
            slot = (px - base_price) / PRICE_STEP;
            if (slot < LEVELS)
            begin
                mark = (act == plbq_pkg::ACT_INSERT) || (qty != 32'd0);
                if (sd == plbq_pkg::SIDE_BID)
                begin
                    bid_price_tab[slot] = px;
                    bid_size_tab[slot]  = qty;
                    bid_marks[slot]     = mark;
                end
                else
                begin
                    ask_price_tab[slot] = px;
                    ask_size_tab[slot]  = qty;
                    ask_marks[slot]     = mark;
                end
                q.accepted = 1'b1;
            end
        end
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (bid_marks[i])
            begin
                q.bid_valid = 1'b1;
                q.bid_price = bid_price_tab[i];
                q.bid_size  = bid_size_tab[i];
                break;
            end
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            if (ask_marks[i])
            begin
                q.ask_valid = 1'b1;
                q.ask_price = ask_price_tab[i];
                q.ask_size  = ask_size_tab[i];
                break;
            end
        end
        return q;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
            begin
                $display("Mismatch on result %0d, %s: expected %h, got %h",
                         quotes_seen, name, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        quote_t want;
        if (!rst_n)
        begin
            base_price = '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                bid_marks[i] = 1'b0;
                ask_marks[i] = 1'b0;
            end
            quote_q.delete();
            errors  <= 0;
            pending <= 0;
            results <= 0;
            applied <= 0;
        end
        else
        begin
            if (done)
            begin
                if (quote_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("Result strobe with no command transfer outstanding");
                    end
                    mismatches++;
                end
                else
                begin
                    want = quote_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(accepted));
                    check_field("bid_valid", 32'(want.bid_valid), 32'(bid_valid));
                    check_field("best_bid_price", want.bid_price, best_bid_price);
                    check_field("best_bid_size", want.bid_size, best_bid_size);
                    check_field("ask_valid", 32'(want.ask_valid), 32'(ask_valid));
                    check_field("best_ask_price", want.ask_price, best_ask_price);
                    check_field("best_ask_size", want.ask_size, best_ask_size);
                end
                quotes_seen++;
            end
            if (cfg_we)
            begin
                base_price = cfg_wdata;
            end
            if (start && !busy)
            begin
                want = write_level(action, side, price, size);
                if (want.accepted)
                begin
                    writes_applied++;
                end
                quote_q.push_back(want);
            end
            errors  <= mismatches;
            pending <= quote_q.size();
            results <= quotes_seen;
            applied <= writes_applied;
        end
    end

endmodule

[bench/price_level_book_best_quote_top_tb.sv]
// ----------------------------------------------------------------------------
// Price level book testbench
// Drives level writes into the price level book: a directed set covering the
// range edges, zero sizes and empty sides, then random phases at several
// min_price settings with random gaps in some phases. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module price_level_book_best_quote_top_tb;

    localparam int unsigned LEVELS     = plbq_pkg::LEVELS_DEF;
    localparam int          IDLE_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        start;
    logic        busy;
    logic        action;
    logic        side;
    logic [31:0] price;
    logic [31:0] size;
    logic        done;
    logic        accepted;
    logic        bid_valid;
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_size;
    logic        ask_valid;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_size;

    int          errors;
    int          pending;
    int          results;
    int          applied;
    int          idle_cycles;
    int          sent;
    int          settings;
    logic [31:0] cur_min;

    price_level_book_best_quote_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .side           (side),
        .price          (price),
        .size           (size),
        .done           (done),
        .accepted       (accepted),
        .bid_valid      (bid_valid),
        .best_bid_price (best_bid_price),
        .best_bid_size  (best_bid_size),
        .ask_valid      (ask_valid),
        .best_ask_price (best_ask_price),
        .best_ask_size  (best_ask_size)
    );

    price_level_book_best_quote_checker book_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .side           (side),
        .price          (price),
        .size           (size),
        .done           (done),
        .accepted       (accepted),
        .bid_valid      (bid_valid),
        .best_bid_price (best_bid_price),
        .best_bid_size  (best_bid_size),
        .ask_valid      (ask_valid),
        .best_ask_price (best_ask_price),
        .best_ask_size  (best_ask_size),
        .errors         (errors),
        .pending        (pending),
        .results        (results),
        .applied        (applied)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_level(input logic act, input logic sd, input logic [31:0] px,
                              input logic [31:0] qty, input bit no_idle);
        int gap;
        int pick;
        start  <= 1'b1;
        action <= act;
        side   <= sd;
        price  <= px;
        size   <= qty;
        do
            @(posedge clk);
        while (busy);
        sent++;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!no_idle)
        begin
            if (pick >= 90)
            begin
                gap = $urandom_range(30, 150);
            end
            else if (pick >= 45)
            begin
                gap = $urandom_range(1, 20);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_min_price(input logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_min = value;
        settings++;
    endtask

    task automatic run_phase(input int count, input int unsigned base,
                             input int unsigned span, input int del_pct,
                             input bit no_idle);
        int          pick;
        logic        act;
        logic        sd;
        logic [31:0] px;
        logic [31:0] qty;
        for (int n = 0; n < count; n++)
        begin
            sd = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < del_pct)
            begin
                qty = '0;
                act = ($urandom_range(0, 3) == 0) ? plbq_pkg::ACT_INSERT
                                                  : plbq_pkg::ACT_UPDATE;
            end
            else
            begin
                qty = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 255);
                act = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                px = cur_min + base + $urandom_range(0, span - 1);
            end
            else if (pick < 83)
            begin
                case ($urandom_range(0, 3))
                    0: px = cur_min;
                    1: px = cur_min + LEVELS - 1;
                    2: px = cur_min + LEVELS;
                    default: px = cur_min + LEVELS + $urandom_range(0, 100000);
                endcase
            end
            else if (pick < 91)
            begin
                px = cur_min - 1 - $urandom_range(0, 5000);
            end
            else
            begin
                px = $urandom;
            end
            send_level(act, sd, px, qty, no_idle);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        start     = 1'b0;
        action    = 1'b0;
        side      = 1'b0;
        price     = '0;
        size      = '0;
        sent      = 0;
        settings  = 0;
        cur_min   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_min_price(32'd0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, 32'd5, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_BID, 32'd0, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, LEVELS - 1, 32'hFFFF_FFFF, 1'b1);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, LEVELS - 1, 32'hFFFF_FFFF, 1'b1);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, 32'd0, 32'd1, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_BID, LEVELS, 32'd4, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'd4, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, LEVELS - 1, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_ASK, 32'd0, 32'd0, 1'b1);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, 32'd100, 32'hA5A5_A5A5, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_ASK, 32'd100, 32'd7, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_BID, 32'd2000, 32'h5A5A_5A5A, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, 32'd2000, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, 32'd0, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_ASK, LEVELS - 1, 32'd0, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_ASK, 32'd100, 32'd0, 1'b0);

        set_min_price(32'hFFFF_FFFF);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'd3, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, 32'hFFFF_FFFE, 32'd3, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_ASK, 32'd0, 32'd9, 1'b0);

        set_min_price(32'hFFFF_F000);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'd8, 1'b0);
        send_level(plbq_pkg::ACT_UPDATE, plbq_pkg::SIDE_BID, 32'hFFFF_F000, 32'd9, 1'b0);
        send_level(plbq_pkg::ACT_INSERT, plbq_pkg::SIDE_BID, 32'hFFFF_EFFF, 32'd9, 1'b0);

        set_min_price(32'd0);
        run_phase(110, $urandom_range(0, LEVELS - 16), 16, 50, 1'b1);
        set_min_price($urandom_range(1, 100000));
        run_phase(110, $urandom_range(0, LEVELS - 32), 32, 35, 1'b0);
        set_min_price(32'hFFFF_F000);
        run_phase(110, LEVELS - 64, 64, 30, 1'b0);
        set_min_price(32'hFFFF_FFFF);
        run_phase(40, 0, 1, 40, 1'b1);
        set_min_price($urandom);
        run_phase(110, $urandom_range(0, LEVELS - 8), 8, 60, 1'b0);
        set_min_price(32'h7FFF_FFFF);
        run_phase(110, $urandom_range(0, LEVELS - 24), 24, 45, 1'b0);
        set_min_price(32'd0);
        run_phase(110, 0, LEVELS, 20, 1'b0);

        wait_drained();
        repeat (40) @(posedge clk);

        $display("Sent %0d level writes over %0d min_price settings: %0d applied, %0d rejected.",
                 sent, settings, applied, sent - applied);
        $display("Checked %0d best quote results, %0d field mismatches.", results, errors);
        if (errors == 0 && pending == 0 && results == sent)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/plbq_pkg.sv
hw/rtl/plbq_ram.sv
hw/rtl/price_level_book_best_quote_top.sv
bench/price_level_book_best_quote_checker.sv
bench/price_level_book_best_quote_top_tb.sv
